// ===== rtl/core/ffha_pkg.sv =====
// ffha_pkg: shared constants, codes and types for the first-fit heap allocator
// used by ffha_round and first_fit_heap_allocator_top; depends on nothing
package ffha_pkg;

  localparam int MAX_SEGMENTS_DEF  = 64;
  localparam int GRANULE_BYTES_DEF = 16;
  localparam int HEADER_BYTES_DEF  = 12;

  localparam int SIZE_W   = 25;
  localparam int ADDR_W   = 32;
  localparam int STATUS_W = 3;
  localparam int REQ_W    = 2;
  localparam int CFG_IW   = 2;

  localparam logic [REQ_W-1:0] REQ_INIT    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ALLOC   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FIT    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DBL_FREE  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

  localparam logic [CFG_IW-1:0] CFG_HEAP_BASE   = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_HEAP_LENGTH = 2'd1;

  localparam logic [ADDR_W-1:0] HEAP_BASE_RST   = 32'h0010_0000;
  localparam logic [SIZE_W-1:0] HEAP_LENGTH_RST = 25'h010_0000;

  typedef struct packed {
    logic              free;
    logic [SIZE_W-1:0] size;
  } seg_t;

endpackage

// ===== rtl/core/ffha_round.sv =====
// ffha_round: rounds a request size up to the granule with a reciprocal multiply
// quotient estimate, remainder and one-step correction; depends on ffha_pkg
module ffha_round #(
  parameter int GRANULE_BYTES = ffha_pkg::GRANULE_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ffha_pkg::SIZE_W-1:0] size_in,
  output logic                        done,
  output logic [ffha_pkg::SIZE_W:0]   need
);
  localparam int SW = ffha_pkg::SIZE_W;
  localparam int RW = $clog2(GRANULE_BYTES + 1);
  localparam logic [31:0] RECIP = 32'((64'd1 << 31) / GRANULE_BYTES);

  logic [SW-1:0]    base_r, base_nxt, quo_r, quo_nxt;
  logic [RW:0]      raw_r, raw_nxt;
  logic [RW-1:0]    rem_r, rem_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic [SW+31:0]   prod;
  logic [SW+RW-1:0] qg;
  logic [SW-1:0]    diff;

  assign done = run_r && (cnt_r == '0);
  assign need = {1'b0, base_r} + ((rem_r == '0) ? '0 :
                (ffha_pkg::SIZE_W+1)'(GRANULE_BYTES) - (ffha_pkg::SIZE_W+1)'(rem_r));

  always_comb begin
    base_nxt = base_r;
    quo_nxt  = quo_r;
    raw_nxt  = raw_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    prod     = (SW+32)'(base_r) * (SW+32)'(RECIP);
    qg       = (SW+RW)'(quo_r) * (SW+RW)'(GRANULE_BYTES);
    diff     = base_r - qg[SW-1:0];
    if (start) begin
      base_nxt = size_in;
      cnt_nxt  = 2'd3;
      run_nxt  = 1'b1;
    end else if (run_r && cnt_r != '0) begin
      case (cnt_r)
        2'd3: quo_nxt = prod[SW+30:31];
        2'd2: raw_nxt = diff[RW:0];
        default: begin
          rem_nxt = (raw_r >= (RW+1)'(GRANULE_BYTES)) ? RW'(raw_r - (RW+1)'(GRANULE_BYTES))
                                                      : RW'(raw_r);
        end
      endcase
      cnt_nxt = cnt_r - 1'b1;
    end else if (done) begin
      run_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
    base_r <= base_nxt;
    quo_r  <= quo_nxt;
    raw_r  <= raw_nxt;
    rem_r  <= rem_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n) start |=> run_r && cnt_r != '0)
    else $error("round unit did not start");
  assert property (@(posedge clk) disable iff (!rst_n) done |-> rem_r < RW'(GRANULE_BYTES))
    else $error("remainder out of range");
  assert property (@(posedge clk) disable iff (!rst_n) done |=> !run_r)
    else $error("round unit did not stop");

endmodule

// ===== rtl/core/first_fit_heap_allocator_top.sv =====
// first_fit_heap_allocator_top: first-fit heap allocator with split and coalesce
// segment table in one synchronous memory; uses ffha_pkg and ffha_round
// allocate: granule rounding, one-entry-per-cycle table walk, shift on split
// release: table walk, on a freed hit a full coalescing pass, one entry per cycle
// one item at a time; next item is taken once the result is in the output register
// reset: synchronous, then S_INIT writes the single free segment, no item taken
module first_fit_heap_allocator_top #(
  parameter int MAX_SEGMENTS  = ffha_pkg::MAX_SEGMENTS_DEF,
  parameter int GRANULE_BYTES = ffha_pkg::GRANULE_BYTES_DEF,
  parameter int HEADER_BYTES  = ffha_pkg::HEADER_BYTES_DEF,
  localparam int CW = $clog2(MAX_SEGMENTS + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ffha_pkg::REQ_W-1:0]    in_req_type,
  input  logic [ffha_pkg::SIZE_W-1:0]   in_alloc_size,
  input  logic [ffha_pkg::ADDR_W-1:0]   in_release_addr,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ffha_pkg::STATUS_W-1:0] out_status,
  output logic [ffha_pkg::ADDR_W-1:0]   out_granted_addr,
  output logic [ffha_pkg::SIZE_W-1:0]   out_used_bytes,
  output logic [ffha_pkg::SIZE_W-1:0]   out_free_bytes,
  output logic [CW-1:0]                 out_segment_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ffha_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [ffha_pkg::ADDR_W-1:0]   cfg_data
);
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int SW = ffha_pkg::SIZE_W;
  localparam int AW = ffha_pkg::ADDR_W;
  localparam logic [SW-1:0] HDR = SW'(HEADER_BYTES);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_ROUND = 4'd2;
  localparam logic [3:0] S_AWALK = 4'd3;
  localparam logic [3:0] S_SHIFT = 4'd4;
  localparam logic [3:0] S_SPLIT = 4'd5;
  localparam logic [3:0] S_TAKE  = 4'd6;
  localparam logic [3:0] S_RWALK = 4'd7;
  localparam logic [3:0] S_MERGE = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  ffha_pkg::seg_t mem [MAX_SEGMENTS];
  ffha_pkg::seg_t rd_data_r, wr_data;
  logic [IW-1:0]  rd_addr, wr_addr;
  logic           rd_en, wr_en;

  logic [3:0]    state_r, state_nxt;
  logic          item_r, item_nxt;
  logic [AW-1:0] heap_base_r;
  logic [SW-1:0] heap_len_r;
  logic [ffha_pkg::REQ_W-1:0] req_r, req_nxt;
  logic [AW-1:0] target_r, target_nxt;
  logic [SW:0]   need_r, need_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [CW-1:0] rd_cnt_r, rd_cnt_nxt;
  logic          pv_r, pv_nxt;
  logic [IW-1:0] proc_idx_r, proc_idx_nxt;
  logic [IW-1:0] hit_idx_r, hit_idx_nxt;
  logic [SW-1:0] hit_size_r, hit_size_nxt, take_size_r, take_size_nxt;
  logic [SW-1:0] used_r, used_nxt, free_r, free_nxt;
  logic [CW-1:0] total_r, total_nxt;
  logic          pend_valid_r, pend_valid_nxt;
  ffha_pkg::seg_t pend_r, pend_nxt;
  logic [CW-1:0] wr_idx_r, wr_idx_nxt;
  logic [ffha_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [AW-1:0] res_granted_r, res_granted_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [ffha_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [AW-1:0] out_granted_r, out_granted_nxt;
  logic [SW-1:0] out_used_r, out_used_nxt, out_free_r, out_free_nxt;
  logic [CW-1:0] out_count_r, out_count_nxt;

  logic          round_start, round_done;
  logic [SW:0]   round_need;
  logic [SW-1:0] size0;
  logic          last_entry;
  logic [AW-1:0] addr_step;

  ffha_round #(.GRANULE_BYTES(GRANULE_BYTES)) u_round (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (round_start),
    .size_in (in_alloc_size),
    .done    (round_done),
    .need    (round_need)
  );

  assign in_ready          = (state_r == S_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_addr  = out_granted_r;
  assign out_used_bytes    = out_used_r;
  assign out_free_bytes    = out_free_r;
  assign out_segment_count = out_count_r;

  assign size0      = (heap_len_r > HDR) ? heap_len_r - HDR : '0;
  assign last_entry = ({1'b0, proc_idx_r} + (IW+1)'(1)) == (IW+1)'(total_r);
  assign addr_step  = addr_r + AW'(HEADER_BYTES) + AW'(rd_data_r.size);

  always_comb begin
    state_nxt       = state_r;
    item_nxt        = item_r;
    req_nxt         = req_r;
    target_nxt      = target_r;
    need_nxt        = need_r;
    addr_nxt        = addr_r;
    rd_cnt_nxt      = rd_cnt_r;
    pv_nxt          = 1'b0;
    hit_idx_nxt     = hit_idx_r;
    hit_size_nxt    = hit_size_r;
    take_size_nxt   = take_size_r;
    used_nxt        = used_r;
    free_nxt        = free_r;
    total_nxt       = total_r;
    pend_valid_nxt  = pend_valid_r;
    pend_nxt        = pend_r;
    wr_idx_nxt      = wr_idx_r;
    res_status_nxt  = res_status_r;
    res_granted_nxt = res_granted_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_status_nxt  = out_status_r;
    out_granted_nxt = out_granted_r;
    out_used_nxt    = out_used_r;
    out_free_nxt    = out_free_r;
    out_count_nxt   = out_count_r;
    round_start     = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = rd_cnt_r[IW-1:0];
    wr_en           = 1'b0;
    wr_addr         = '0;
    wr_data         = '0;
    proc_idx_nxt    = rd_cnt_r[IW-1:0];

    case (state_r)
      S_INIT: begin
        wr_en     = 1'b1;
        wr_data   = '{free: 1'b1, size: size0};
        used_nxt  = '0;
        free_nxt  = size0;
        total_nxt = CW'(1);
        state_nxt = item_r ? S_DONE : S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          item_nxt        = 1'b1;
          req_nxt         = in_req_type;
          target_nxt      = in_release_addr;
          res_status_nxt  = ffha_pkg::ST_OK;
          res_granted_nxt = '0;
          rd_cnt_nxt      = '0;
          addr_nxt        = heap_base_r + AW'(HEADER_BYTES);
          case (in_req_type)
            ffha_pkg::REQ_INIT: state_nxt = S_INIT;
            ffha_pkg::REQ_ALLOC: begin
              round_start = 1'b1;
              state_nxt   = S_ROUND;
            end
            ffha_pkg::REQ_RELEASE: begin
              if (in_release_addr == '0) begin
                res_status_nxt = ffha_pkg::ST_NULL;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_RWALK;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_ROUND: begin
        if (round_done) begin
          need_nxt  = round_need;
          state_nxt = S_AWALK;
        end
      end
      S_AWALK: begin
        rd_en  = rd_cnt_r < total_r;
        pv_nxt = rd_en;
        if (rd_en) rd_cnt_nxt = rd_cnt_r + 1'b1;
        if (pv_r) begin
          if (rd_data_r.free && {1'b0, rd_data_r.size} >= need_r) begin
            pv_nxt          = 1'b0;
            hit_idx_nxt     = proc_idx_r;
            hit_size_nxt    = rd_data_r.size;
            res_granted_nxt = addr_r;
            if ({2'b0, rd_data_r.size} >
                {1'b0, need_r} + (SW+2)'(HEADER_BYTES) + (SW+2)'(GRANULE_BYTES) &&
                total_r < CW'(MAX_SEGMENTS)) begin
              take_size_nxt = need_r[SW-1:0];
              used_nxt      = used_r + need_r[SW-1:0];
              free_nxt      = free_r - need_r[SW-1:0] - HDR;
              total_nxt     = total_r + 1'b1;
              rd_cnt_nxt    = total_r - 1'b1;
              state_nxt     = S_SHIFT;
            end else begin
              take_size_nxt = rd_data_r.size;
              used_nxt      = used_r + rd_data_r.size;
              free_nxt      = free_r - rd_data_r.size;
              state_nxt     = S_TAKE;
            end
          end else begin
            addr_nxt = addr_step;
            if (last_entry) begin
              pv_nxt         = 1'b0;
              res_status_nxt = ffha_pkg::ST_NO_FIT;
              state_nxt      = S_DONE;
            end
          end
        end
      end
      S_SHIFT: begin
        rd_en  = rd_cnt_r > CW'(hit_idx_r);
        pv_nxt = rd_en;
        if (rd_en) rd_cnt_nxt = rd_cnt_r - 1'b1;
        if (pv_r) begin
          wr_en   = 1'b1;
          wr_addr = proc_idx_r + 1'b1;
          wr_data = rd_data_r;
        end
        if (!rd_en && !pv_r) state_nxt = S_SPLIT;
      end
      S_SPLIT: begin
        wr_en     = 1'b1;
        wr_addr   = hit_idx_r + 1'b1;
        wr_data   = '{free: 1'b1, size: hit_size_r - need_r[SW-1:0] - HDR};
        state_nxt = S_TAKE;
      end
      S_TAKE: begin
        wr_en     = 1'b1;
        wr_addr   = hit_idx_r;
        wr_data   = '{free: 1'b0, size: take_size_r};
        state_nxt = S_DONE;
      end
      S_RWALK: begin
        rd_en  = rd_cnt_r < total_r;
        pv_nxt = rd_en;
        if (rd_en) rd_cnt_nxt = rd_cnt_r + 1'b1;
        if (pv_r) begin
          if (addr_r == target_r) begin
            pv_nxt = 1'b0;
            if (rd_data_r.free) begin
              res_status_nxt = ffha_pkg::ST_DBL_FREE;
              state_nxt      = S_DONE;
            end else begin
              wr_en          = 1'b1;
              wr_addr        = proc_idx_r;
              wr_data        = '{free: 1'b1, size: rd_data_r.size};
              used_nxt       = used_r - rd_data_r.size;
              free_nxt       = free_r + rd_data_r.size;
              rd_cnt_nxt     = '0;
              wr_idx_nxt     = '0;
              pend_valid_nxt = 1'b0;
              state_nxt      = S_MERGE;
            end
          end else begin
            addr_nxt = addr_step;
            if (last_entry) begin
              pv_nxt         = 1'b0;
              res_status_nxt = ffha_pkg::ST_NOT_FOUND;
              state_nxt      = S_DONE;
            end
          end
        end
      end
      S_MERGE: begin
        rd_en  = rd_cnt_r < total_r;
        pv_nxt = rd_en;
        if (rd_en) rd_cnt_nxt = rd_cnt_r + 1'b1;
        if (pv_r) begin
          if (!pend_valid_r) begin
            pend_valid_nxt = 1'b1;
            pend_nxt       = rd_data_r;
          end else if (pend_r.free && rd_data_r.free) begin
            pend_nxt.size = pend_r.size + HDR + rd_data_r.size;
            free_nxt      = free_r + HDR;
          end else begin
            wr_en      = 1'b1;
            wr_addr    = wr_idx_r[IW-1:0];
            wr_data    = pend_r;
            wr_idx_nxt = wr_idx_r + 1'b1;
            pend_nxt   = rd_data_r;
          end
        end
        if (!rd_en && !pv_r) begin
          wr_en     = 1'b1;
          wr_addr   = wr_idx_r[IW-1:0];
          wr_data   = pend_r;
          total_nxt = wr_idx_r + 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = res_status_r;
          out_granted_nxt = res_granted_r;
          out_used_nxt    = used_r;
          out_free_nxt    = free_r;
          out_count_nxt   = total_r;
          item_nxt        = 1'b0;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      item_r      <= 1'b0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      heap_base_r <= ffha_pkg::HEAP_BASE_RST;
      heap_len_r  <= ffha_pkg::HEAP_LENGTH_RST;
    end else begin
      state_r     <= state_nxt;
      item_r      <= item_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          ffha_pkg::CFG_HEAP_BASE:   heap_base_r <= cfg_data;
          ffha_pkg::CFG_HEAP_LENGTH: heap_len_r  <= cfg_data[SW-1:0];
          default: ;
        endcase
      end
    end
    req_r         <= req_nxt;
    target_r      <= target_nxt;
    need_r        <= need_nxt;
    addr_r        <= addr_nxt;
    rd_cnt_r      <= rd_cnt_nxt;
    proc_idx_r    <= proc_idx_nxt;
    hit_idx_r     <= hit_idx_nxt;
    hit_size_r    <= hit_size_nxt;
    take_size_r   <= take_size_nxt;
    used_r        <= used_nxt;
    free_r        <= free_nxt;
    total_r       <= total_nxt;
    pend_valid_r  <= pend_valid_nxt;
    pend_r        <= pend_nxt;
    wr_idx_r      <= wr_idx_nxt;
    res_status_r  <= res_status_nxt;
    res_granted_r <= res_granted_nxt;
    out_status_r  <= out_status_nxt;
    out_granted_r <= out_granted_nxt;
    out_used_r    <= out_used_nxt;
    out_free_r    <= out_free_nxt;
    out_count_r   <= out_count_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_INIT && state_r != S_MERGE |-> total_r != '0 && total_r <= CW'(MAX_SEGMENTS))
    else $error("segment count out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MERGE && pv_r |-> wr_idx_r <= CW'(proc_idx_r))
    else $error("coalescing write overtook the read");
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != S_IDLE)
    else $error("accepted transfer left no work");
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result shown outside completion");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SPLIT |-> CW'(hit_idx_r) + 1'b1 < total_r)
    else $error("split past end of table");

endmodule

// ===== verif/first_fit_heap_allocator_top_test.sv =====
// first_fit_heap_allocator_top_test: self-checking testbench for the first-fit heap allocator
// holds a table predictor, directed and random request phases, and a result scoreboard
// depends on ffha_pkg and first_fit_heap_allocator_top
`timescale 1ns / 1ps

module first_fit_heap_allocator_top_test;

  localparam int NSEG = ffha_pkg::MAX_SEGMENTS_DEF;
  localparam int GRAN = ffha_pkg::GRANULE_BYTES_DEF;
  localparam int HDR  = ffha_pkg::HEADER_BYTES_DEF;
  localparam int CW   = $clog2(NSEG + 1);
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [ffha_pkg::REQ_W-1:0] REQ_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [ffha_pkg::STATUS_W-1:0] status;
    logic [ffha_pkg::ADDR_W-1:0]   granted;
    logic [ffha_pkg::SIZE_W-1:0]   used;
    logic [ffha_pkg::SIZE_W-1:0]   free_b;
    logic [CW-1:0]                 count;
  } heap_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [ffha_pkg::REQ_W-1:0] in_req_type = '0;
  logic [ffha_pkg::SIZE_W-1:0] in_alloc_size = '0;
  logic [ffha_pkg::ADDR_W-1:0] in_release_addr = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ffha_pkg::STATUS_W-1:0] out_status;
  logic [ffha_pkg::ADDR_W-1:0] out_granted_addr;
  logic [ffha_pkg::SIZE_W-1:0] out_used_bytes;
  logic [ffha_pkg::SIZE_W-1:0] out_free_bytes;
  logic [CW-1:0] out_segment_count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ffha_pkg::CFG_IW-1:0] cfg_index = '0;
  logic [ffha_pkg::ADDR_W-1:0] cfg_data = '0;

  first_fit_heap_allocator_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [ffha_pkg::SIZE_W-1:0] seg_size [NSEG];
  logic                        seg_free [NSEG];
  int unsigned                 seg_cnt;
  logic [ffha_pkg::ADDR_W-1:0] heap_base_q;
  logic [ffha_pkg::SIZE_W-1:0] heap_len_q;

  heap_result_t pending_results[$];
  int sender_idle = 0;
  int recv_idle = 0;
  int mismatches = 0;
  int checked = 0;
  int sent_items = 0;
  int grants = 0;
  int full_table_hits = 0;
  int idle_cycles = 0;

  function automatic void table_reset();
    for (int i = 0; i < NSEG; i++) begin
      seg_size[i] = '0;
      seg_free[i] = 1'b0;
    end
    seg_size[0] = (heap_len_q > HDR) ? ffha_pkg::SIZE_W'(heap_len_q - HDR) : '0;
    seg_free[0] = 1'b1;
    seg_cnt = 1;
  endfunction

  function automatic logic [ffha_pkg::ADDR_W-1:0] seg_addr(input int unsigned j);
    logic [ffha_pkg::ADDR_W-1:0] a;
    a = heap_base_q + HDR;
    for (int unsigned i = 0; i < j; i++) a = a + HDR + seg_size[i];
    return a;
  endfunction

  function automatic void heap_coalesce();
    int unsigned i;
    i = 0;
    while (i + 1 < seg_cnt) begin
      if (seg_free[i] && seg_free[i+1]) begin
        seg_size[i] = ffha_pkg::SIZE_W'(seg_size[i] + HDR + seg_size[i+1]);
        for (int unsigned k = i + 1; k + 1 < seg_cnt; k++) begin
          seg_size[k] = seg_size[k+1];
          seg_free[k] = seg_free[k+1];
        end
        seg_cnt--;
        seg_size[seg_cnt] = '0;
        seg_free[seg_cnt] = 1'b0;
      end else begin
        i++;
      end
    end
  endfunction

  function automatic void heap_alloc(input logic [ffha_pkg::SIZE_W-1:0] req,
                                     output logic [ffha_pkg::STATUS_W-1:0] st,
                                     output logic [ffha_pkg::ADDR_W-1:0] g);
    longint unsigned need, sz;
    logic [ffha_pkg::ADDR_W-1:0] a;
    need = req;
    if (need % GRAN != 0) need += GRAN - (need % GRAN);
    a = heap_base_q + HDR;
    st = ffha_pkg::ST_NO_FIT;
    g = '0;
    for (int unsigned i = 0; i < seg_cnt; i++) begin
      sz = seg_size[i];
      if (seg_free[i] && sz >= need) begin
        if (sz > need + HDR + GRAN) begin
          if (seg_cnt < NSEG) begin
            for (int unsigned k = seg_cnt; k > i + 1; k--) begin
              seg_size[k] = seg_size[k-1];
              seg_free[k] = seg_free[k-1];
            end
            seg_size[i+1] = ffha_pkg::SIZE_W'(sz - need - HDR);
            seg_free[i+1] = 1'b1;
            seg_size[i] = ffha_pkg::SIZE_W'(need);
            seg_cnt++;
          end else begin
            full_table_hits++;
          end
        end
        seg_free[i] = 1'b0;
        st = ffha_pkg::ST_OK;
        g = a;
        return;
      end
      a = a + HDR + seg_size[i];
    end
  endfunction

  function automatic logic [ffha_pkg::STATUS_W-1:0] heap_release(
      input logic [ffha_pkg::ADDR_W-1:0] target);
    logic [ffha_pkg::ADDR_W-1:0] a;
    if (target == '0) return ffha_pkg::ST_NULL;
    a = heap_base_q + HDR;
    for (int unsigned i = 0; i < seg_cnt; i++) begin
      if (a == target) begin
        if (seg_free[i]) return ffha_pkg::ST_DBL_FREE;
        seg_free[i] = 1'b1;
        heap_coalesce();
        return ffha_pkg::ST_OK;
      end
      a = a + HDR + seg_size[i];
    end
    return ffha_pkg::ST_NOT_FOUND;
  endfunction

  function automatic heap_result_t predict_request(input logic [ffha_pkg::REQ_W-1:0] req,
                                                   input logic [ffha_pkg::SIZE_W-1:0] sz,
                                                   input logic [ffha_pkg::ADDR_W-1:0] addr);
    heap_result_t r;
    logic [ffha_pkg::SIZE_W-1:0] u, f;
    r = '0;
    if (req == ffha_pkg::REQ_INIT) table_reset();
    else if (req == ffha_pkg::REQ_ALLOC) heap_alloc(sz, r.status, r.granted);
    else if (req == ffha_pkg::REQ_RELEASE) r.status = heap_release(addr);
    u = '0;
    f = '0;
    for (int unsigned i = 0; i < seg_cnt; i++) begin
      if (seg_free[i]) f = f + seg_size[i];
      else u = u + seg_size[i];
    end
    r.used = u;
    r.free_b = f;
    r.count = CW'(seg_cnt);
    return r;
  endfunction

  task automatic send_request(input logic [ffha_pkg::REQ_W-1:0] req,
                              input logic [ffha_pkg::SIZE_W-1:0] sz,
                              input logic [ffha_pkg::ADDR_W-1:0] addr);
    in_valid <= 1'b1;
    in_req_type <= req;
    in_alloc_size <= sz;
    in_release_addr <= addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_request(req, sz, addr));
    if (pending_results[$].granted != '0) grants++;
    sent_items++;
    if ($urandom_range(99) < sender_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * NSEG + 40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ffha_pkg::CFG_IW-1:0] idx,
                           input logic [ffha_pkg::ADDR_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == ffha_pkg::CFG_HEAP_BASE) heap_base_q = data;
    else heap_len_q = data[ffha_pkg::SIZE_W-1:0];
    @(posedge clk);
  endtask

  task automatic test_basic_requests();
    logic [ffha_pkg::ADDR_W-1:0] a0, a1;
    send_request(ffha_pkg::REQ_INIT, '0, '0);
    send_request(ffha_pkg::REQ_ALLOC, '0, '0);
    send_request(ffha_pkg::REQ_ALLOC, 25'd1, '0);
    send_request(ffha_pkg::REQ_ALLOC, 25'd16, '0);
    send_request(ffha_pkg::REQ_ALLOC, 25'd17, '0);
    send_request(ffha_pkg::REQ_ALLOC, 25'd16777216, '0);
    send_request(ffha_pkg::REQ_ALLOC, 25'h1FF_FFFF, '0);
    send_request(ffha_pkg::REQ_RELEASE, '0, '0);
    a0 = seg_addr(1);
    a1 = seg_addr(2);
    send_request(ffha_pkg::REQ_RELEASE, '0, a0);
    send_request(ffha_pkg::REQ_RELEASE, '0, a0);
    send_request(ffha_pkg::REQ_RELEASE, '0, heap_base_q + HDR + 1);
    send_request(REQ_UNKNOWN, 25'h1FF_FFFF, 32'hFFFF_FFFF);
    send_request(ffha_pkg::REQ_RELEASE, '0, a1);
    send_request(ffha_pkg::REQ_ALLOC, 25'd1000000, '0);
    send_request(ffha_pkg::REQ_INIT, '0, '0);
    drain();
  endtask

  task automatic test_heap_edges();
    write_reg(ffha_pkg::CFG_HEAP_LENGTH, 32'd5);
    send_request(ffha_pkg::REQ_INIT, '0, '0);
    send_request(ffha_pkg::REQ_ALLOC, '0, '0);
    send_request(ffha_pkg::REQ_ALLOC, 25'd1, '0);
    drain();
    write_reg(ffha_pkg::CFG_HEAP_LENGTH, 32'd0);
    write_reg(ffha_pkg::CFG_HEAP_BASE, 32'hFFFF_FFFF);
    send_request(ffha_pkg::REQ_INIT, '0, '0);
    send_request(ffha_pkg::REQ_ALLOC, '0, '0);
    drain();
    write_reg(ffha_pkg::CFG_HEAP_BASE, 32'hFFFF_FFF8);
    write_reg(ffha_pkg::CFG_HEAP_LENGTH, 32'd96);
    send_request(ffha_pkg::REQ_INIT, '0, '0);
    send_request(ffha_pkg::REQ_ALLOC, '0, '0);
    send_request(ffha_pkg::REQ_ALLOC, 25'd16, '0);
    send_request(ffha_pkg::REQ_RELEASE, '0, 32'd4);
    send_request(ffha_pkg::REQ_RELEASE, '0, seg_addr(1));
    drain();
  endtask

  task automatic test_random_traffic(input int n_items, input int s_idle, input int r_idle,
                                     input logic [ffha_pkg::ADDR_W-1:0] base,
                                     input logic [ffha_pkg::SIZE_W-1:0] len,
                                     input int alloc_pct);
    int r;
    logic [ffha_pkg::REQ_W-1:0] req;
    logic [ffha_pkg::SIZE_W-1:0] sz;
    logic [ffha_pkg::ADDR_W-1:0] addr;
    sender_idle = s_idle;
    recv_idle = r_idle;
    write_reg(ffha_pkg::CFG_HEAP_BASE, base);
    write_reg(ffha_pkg::CFG_HEAP_LENGTH, 32'(len));
    send_request(ffha_pkg::REQ_INIT, '0, '0);
    for (int n = 0; n < n_items; n++) begin
      r = $urandom_range(99);
      sz = ffha_pkg::SIZE_W'($urandom);
      addr = $urandom;
      if (r < 2) req = ffha_pkg::REQ_INIT;
      else if (r < 4) req = REQ_UNKNOWN;
      else if (r < 4 + alloc_pct) req = ffha_pkg::REQ_ALLOC;
      else req = ffha_pkg::REQ_RELEASE;
      if (req == ffha_pkg::REQ_ALLOC) begin
        r = $urandom_range(99);
        if (r < 70) sz = ffha_pkg::SIZE_W'($urandom_range(0, 300));
        else if (r < 90) sz = ffha_pkg::SIZE_W'($urandom_range(0, 65536));
        else if (r < 95) sz = ffha_pkg::SIZE_W'(32'd16777216 - $urandom_range(0, 40));
      end else if (req == ffha_pkg::REQ_RELEASE) begin
        r = $urandom_range(99);
        if (r < 75) addr = seg_addr($urandom_range(0, seg_cnt - 1));
        else if (r < 85) addr = '0;
        else if (r < 92) addr = seg_addr($urandom_range(0, seg_cnt - 1)) + $urandom_range(1, 20);
      end
      send_request(req, sz, addr);
    end
    drain();
  endtask

  // result checking and receiver backpressure
  always @(posedge clk) begin
    heap_result_t exp_r, got;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_status, out_granted_addr, out_used_bytes, out_free_bytes, out_segment_count};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: %p", got);
      end else begin
        exp_r = pending_results.pop_front();
        checked++;
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch st %0d/%0d addr %h/%h used %0d/%0d free %0d/%0d cnt %0d/%0d",
                     exp_r.status, got.status, exp_r.granted, got.granted, exp_r.used,
                     got.used, exp_r.free_b, got.free_b, exp_r.count, got.count);
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    heap_base_q = ffha_pkg::HEAP_BASE_RST;
    heap_len_q = ffha_pkg::HEAP_LENGTH_RST;
    table_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_requests();
    test_heap_edges();
    test_random_traffic(440, 11, 66, ffha_pkg::HEAP_BASE_RST, ffha_pkg::HEAP_LENGTH_RST, 60);
    test_random_traffic(440, 66, 11, 32'hFFFF_F000, 25'd8192, 48);
    test_random_traffic(440, 0, 0, 32'h0, 25'd16777216, 52);
    $display("sent %0d requests, checked %0d results, %0d grants, %0d full-table grants",
             sent_items, checked, grants, full_table_hits);
    $display("heap settings covered: reset, tiny, empty, wrapping base, full 16 MiB");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
